FILE: hdl/hbd_pkg.sv
// ----------------------------------------------------------------------------
// hbd_pkg
// Shared types, constants and a helper of the http body dechunker.
// ----------------------------------------------------------------------------
package hbd_pkg;

  localparam int COUNT_WIDTH = 32;
  localparam int BYTE_W      = 8;
  localparam int LEN_W       = 32;
  localparam int KIND_W      = 2;
  localparam int DIGIT_W     = 4;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 32;
  localparam int CMP_W       = (COUNT_WIDTH > LEN_W) ? COUNT_WIDTH : LEN_W;
  localparam int MAX_DIGITS  = 8;

  localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;

  localparam logic [CFG_IDX_W-1:0] REG_CHUNKED_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CONTENT_LENGTH = 2'd1;

  typedef enum logic [3:0] {
    PH_LEAD   = 4'd0,
    PH_DIGITS = 4'd1,
    PH_EXT    = 4'd2,
    PH_LF     = 4'd3,
    PH_DATA   = 4'd4,
    PH_POST1  = 4'd5,
    PH_POST2  = 4'd6,
    PH_TRAIL  = 4'd7,
    PH_TLF    = 4'd8,
    PH_DONE   = 4'd9,
    PH_ERROR  = 4'd10
  } phase_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_PAY  = 2'd0,
    KIND_LAST = 2'd1,
    KIND_END  = 2'd2,
    KIND_BAD  = 2'd3
  } kind_t;

  typedef struct packed {
    logic              is_hex;
    logic [DIGIT_W-1:0] value;
  } hex_t;

  // ascii hex digit decode
  function automatic hex_t hex_decode(input logic [BYTE_W-1:0] c);
    hex_t h;
    h.is_hex = 1'b0;
    h.value  = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.is_hex = 1'b1;
      h.value  = DIGIT_W'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      h.is_hex = 1'b1;
      h.value  = DIGIT_W'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      h.is_hex = 1'b1;
      h.value  = DIGIT_W'(c - 8'h37);
    end
    return h;
  endfunction

endpackage

FILE: hdl/hbd_in_if.sv
// ----------------------------------------------------------------------------
// hbd_in_if
// Raw body byte channel with valid/ready handshake.
// ----------------------------------------------------------------------------
interface hbd_in_if;
  logic                       valid;
  logic                       ready;
  logic [hbd_pkg::BYTE_W-1:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

FILE: hdl/hbd_out_if.sv
// ----------------------------------------------------------------------------
// hbd_out_if
// Decoded result channel: payload byte and result kind.
// ----------------------------------------------------------------------------
interface hbd_out_if;
  logic                       valid;
  logic                       ready;
  logic [hbd_pkg::BYTE_W-1:0] data;
  logic [hbd_pkg::KIND_W-1:0] kind;

  modport source (output valid, output data, output kind, input ready);
  modport sink   (input valid, input data, input kind, output ready);
endinterface

FILE: hdl/hbd_cfg_if.sv
// ----------------------------------------------------------------------------
// hbd_cfg_if
// Register write channel: register index and write data.
// ----------------------------------------------------------------------------
interface hbd_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [hbd_pkg::CFG_IDX_W-1:0]  index;
  logic [hbd_pkg::CFG_DATA_W-1:0] wdata;

  modport source (output valid, output index, output wdata, input ready);
  modport sink   (input valid, input index, input wdata, output ready);
endinterface

FILE: hdl/http_body_dechunker_core.sv
// ----------------------------------------------------------------------------
// http_body_dechunker_core
// Decodes an http message body, fixed length or chunked, one byte per word.
// ----------------------------------------------------------------------------
// path: an accepted byte waits in the input register; the decode step then writes
//   its result, if any, to the result register (input reg, result reg)
// throughput: one byte per cycle unless the result register is full and not
//   taken; the decode step between the two registers updates the parser state for each byte
// stall: an input word waits in the input register while the result register
//   is full and not taken
// reset: rst_n synchronous active low; clears parser state, config and valids
module http_body_dechunker_core (
  input  logic         clk,
  input  logic         rst_n,
  hbd_in_if.sink       in_ch,
  hbd_out_if.source    out_ch,
  hbd_cfg_if.sink      cfg_ch
);
  import hbd_pkg::*;

  // config registers
  logic             chunked_mode_r;
  logic [LEN_W-1:0] content_length_r;

  // input register
  logic              in_v_r;
  logic [BYTE_W-1:0] in_byte_r;

  // parser state
  phase_t                 phase_r, phase_nxt;
  logic [LEN_W-1:0]       remaining_r, remaining_nxt;
  logic [COUNT_WIDTH-1:0] passed_r, passed_nxt;
  logic [DIGIT_W-1:0]     digit_cnt_r, digit_cnt_nxt;
  logic                   line_empty_r, line_empty_nxt;

  // result register
  logic              out_v_r;
  logic [BYTE_W-1:0] out_data_r;
  kind_t             out_kind_r;

  logic              res_v;
  logic [BYTE_W-1:0] res_data;
  kind_t             res_kind;

  logic                   proc;
  logic                   in_take;
  hex_t                   hx;
  logic                   stopped;
  logic [COUNT_WIDTH-1:0] passed_inc;
  logic [LEN_W-1:0]       rem_dec;
  logic                   len_open;
  logic                   len_hit;

  assign proc    = in_v_r && (!out_v_r || out_ch.ready);
  assign in_take = !in_v_r || proc;

  assign in_ch.ready  = in_take;
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = out_v_r;
  assign out_ch.data  = out_data_r;
  assign out_ch.kind  = out_kind_r;

  assign hx         = hex_decode(in_byte_r);
  assign stopped    = (phase_r == PH_DONE) || (phase_r == PH_ERROR);
  assign passed_inc = passed_r + COUNT_WIDTH'(1);
  assign rem_dec    = remaining_r - LEN_W'(1);
  assign len_open   = CMP_W'(passed_r) < CMP_W'(content_length_r);
  assign len_hit    = CMP_W'(passed_inc) == CMP_W'(content_length_r);

  // next state
  always_comb begin
    phase_nxt      = phase_r;
    remaining_nxt  = remaining_r;
    passed_nxt     = passed_r;
    digit_cnt_nxt  = digit_cnt_r;
    line_empty_nxt = line_empty_r;
    if (!stopped) begin
      if (!chunked_mode_r) begin
        if (len_open) begin
          passed_nxt = passed_inc;
          if (len_hit) begin
            phase_nxt = PH_DONE;
          end
        end
      end else begin
        unique case (phase_r)
          PH_LEAD: begin
            if (in_byte_r != CH_SPACE && in_byte_r != CH_TAB) begin
              if (!hx.is_hex) begin
                phase_nxt = PH_ERROR;
              end else begin
                remaining_nxt = LEN_W'(hx.value);
                digit_cnt_nxt = DIGIT_W'(1);
                phase_nxt     = PH_DIGITS;
              end
            end
          end
          PH_DIGITS: begin
            if (hx.is_hex) begin
              if (digit_cnt_r >= DIGIT_W'(MAX_DIGITS)) begin
                phase_nxt = PH_ERROR;
              end else begin
                remaining_nxt = {remaining_r[LEN_W-DIGIT_W-1:0], hx.value};
                digit_cnt_nxt = digit_cnt_r + DIGIT_W'(1);
              end
            end else if (in_byte_r == CH_CR) begin
              phase_nxt = PH_LF;
            end else begin
              phase_nxt = PH_EXT;
            end
          end
          PH_EXT: begin
            if (in_byte_r == CH_CR) begin
              phase_nxt = PH_LF;
            end
          end
          PH_LF: begin
            if (remaining_r == '0) begin
              line_empty_nxt = 1'b1;
              phase_nxt      = PH_TRAIL;
            end else begin
              phase_nxt = PH_DATA;
            end
          end
          PH_DATA: begin
            remaining_nxt = rem_dec;
            passed_nxt    = passed_inc;
            if (rem_dec == '0) begin
              phase_nxt = PH_POST1;
            end
          end
          PH_POST1: phase_nxt = PH_POST2;
          PH_POST2: begin
            digit_cnt_nxt = '0;
            phase_nxt     = PH_LEAD;
          end
          PH_TRAIL: begin
            if (in_byte_r == CH_CR) begin
              phase_nxt = PH_TLF;
            end else begin
              line_empty_nxt = 1'b0;
            end
          end
          PH_TLF: begin
            if (line_empty_r) begin
              phase_nxt = PH_DONE;
            end else begin
              line_empty_nxt = 1'b1;
              phase_nxt      = PH_TRAIL;
            end
          end
          default: phase_nxt = PH_ERROR;
        endcase
      end
    end
  end

  // result of the current byte
  always_comb begin
    res_v    = 1'b0;
    res_data = '0;
    res_kind = KIND_PAY;
    if (!stopped) begin
      if (!chunked_mode_r) begin
        if (len_open) begin
          res_v    = 1'b1;
          res_data = in_byte_r;
          res_kind = len_hit ? KIND_LAST : KIND_PAY;
        end
      end else begin
        unique case (phase_r)
          PH_LEAD: begin
            if (in_byte_r != CH_SPACE && in_byte_r != CH_TAB && !hx.is_hex) begin
              res_v    = 1'b1;
              res_kind = KIND_BAD;
            end
          end
          PH_DIGITS: begin
            if (hx.is_hex && digit_cnt_r >= DIGIT_W'(MAX_DIGITS)) begin
              res_v    = 1'b1;
              res_kind = KIND_BAD;
            end
          end
          PH_DATA: begin
            res_v    = 1'b1;
            res_data = in_byte_r;
          end
          PH_TLF: begin
            if (line_empty_r) begin
              res_v    = 1'b1;
              res_kind = KIND_END;
            end
          end
          default: res_v = 1'b0;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chunked_mode_r   <= 1'b0;
      content_length_r <= '0;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_CHUNKED_MODE:   chunked_mode_r   <= cfg_ch.wdata[0];
        REG_CONTENT_LENGTH: content_length_r <= cfg_ch.wdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_take) begin
      in_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take && in_ch.valid) begin
      in_byte_r <= in_ch.in_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_LEAD;
      remaining_r  <= '0;
      passed_r     <= '0;
      digit_cnt_r  <= '0;
      line_empty_r <= 1'b1;
    end else if (proc) begin
      phase_r      <= phase_nxt;
      remaining_r  <= remaining_nxt;
      passed_r     <= passed_nxt;
      digit_cnt_r  <= digit_cnt_nxt;
      line_empty_r <= line_empty_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (proc && res_v) begin
      out_v_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc && res_v) begin
      out_data_r <= res_data;
      out_kind_r <= res_kind;
    end
  end

  // a failed or finished body stays so
  a_stop_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_DONE || phase_r == PH_ERROR) |=> $stable(phase_r))
    else $error("parser left a terminal phase");

  // an error word is only ever shown with the parser in error
  a_bad_means_error: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_kind_r == KIND_BAD) |-> phase_r == PH_ERROR)
    else $error("malformed result without error phase");

  // last byte of a length body ends the parse
  a_last_means_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_kind_r == KIND_LAST) |-> phase_r == PH_DONE)
    else $error("last byte result without done phase");

  a_digit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    digit_cnt_r <= DIGIT_W'(MAX_DIGITS))
    else $error("size line digit count overflow");

  // input register only blocks while it holds a word
  a_ready_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (in_v_r && out_v_r && !out_ch.ready))
    else $error("input stalled without a pending word");

endmodule

FILE: tb/tb_http_body_dechunker_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_http_body_dechunker_core
// Feeds body bytes in length and chunked mode through a short table of
// directed words and a long run of random chunked bodies, and checks every
// decoded word against a behavioral decoder kept in step with the stream.
// ----------------------------------------------------------------------------
module tb_http_body_dechunker_core;
  import hbd_pkg::*;

  localparam int RANDOM_BYTES = 1700;
  localparam int DRAIN_CYCLES = 6;
  localparam int QUIET_LIMIT  = 2000;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    kind_t             kind;
  } word_t;

  typedef enum logic [1:0] {ROW_BYTE, ROW_REG} row_op_t;
  typedef enum logic [1:0] {GOLD_CALC, GOLD_WORD, GOLD_NONE} gold_t;

  typedef struct packed {
    row_op_t               op;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] val;
    gold_t                 gold;
    word_t                 word;
  } row_t;

  localparam int N_ROWS = 28;
  localparam row_t DIRECTED [N_ROWS] = '{
    // empty length body right after reset
    '{ROW_BYTE, '0, 32'h00, GOLD_NONE, '{8'h00, KIND_PAY}},
    '{ROW_BYTE, '0, 32'hFF, GOLD_NONE, '{8'h00, KIND_PAY}},
    '{ROW_REG, REG_CHUNKED_MODE, 32'h1, GOLD_CALC, '{8'h00, KIND_PAY}},
    // blanks, eight digits, extension, skipped byte after cr
    '{ROW_BYTE, '0, 32'h20, GOLD_NONE, '{8'h00, KIND_PAY}},
    '{ROW_BYTE, '0, 32'h09, GOLD_NONE, '{8'h00, KIND_PAY}},
    '{ROW_BYTE, '0, 32'h30, GOLD_NONE, '{8'h00, KIND_PAY}},
    '{ROW_BYTE, '0, 32'h30, GOLD_NONE, '{8'h00, KIND_PAY}},
    '{ROW_BYTE, '0, 32'h30, GOLD_NONE, '{8'h00, KIND_PAY}},
    '{ROW_BYTE, '0, 32'h30, GOLD_NONE, '{8'h00, KIND_PAY}},
    '{ROW_BYTE, '0, 32'h30, GOLD_NONE, '{8'h00, KIND_PAY}},
    '{ROW_BYTE, '0, 32'h30, GOLD_NONE, '{8'h00, KIND_PAY}},
    '{ROW_BYTE, '0, 32'h30, GOLD_NONE, '{8'h00, KIND_PAY}},
    '{ROW_BYTE, '0, 32'h33, GOLD_NONE, '{8'h00, KIND_PAY}},
    '{ROW_BYTE, '0, 32'h3B, GOLD_NONE, '{8'h00, KIND_PAY}},
    '{ROW_BYTE, '0, 32'hFF, GOLD_NONE, '{8'h00, KIND_PAY}},
    '{ROW_BYTE, '0, 32'h0D, GOLD_NONE, '{8'h00, KIND_PAY}},
    '{ROW_BYTE, '0, 32'h00, GOLD_NONE, '{8'h00, KIND_PAY}},
    // three data bytes, then the two skipped ones
    '{ROW_BYTE, '0, 32'h00, GOLD_WORD, '{8'h00, KIND_PAY}},
    '{ROW_BYTE, '0, 32'hFF, GOLD_WORD, '{8'hFF, KIND_PAY}},
    '{ROW_BYTE, '0, 32'h80, GOLD_CALC, '{8'h00, KIND_PAY}},
    '{ROW_BYTE, '0, 32'h0D, GOLD_CALC, '{8'h00, KIND_PAY}},
    '{ROW_BYTE, '0, 32'h41, GOLD_CALC, '{8'h00, KIND_PAY}},
    // length mode at the largest and smallest length
    '{ROW_REG, REG_CHUNKED_MODE, 32'h0, GOLD_CALC, '{8'h00, KIND_PAY}},
    '{ROW_REG, REG_CONTENT_LENGTH, 32'hFFFF_FFFF, GOLD_CALC, '{8'h00, KIND_PAY}},
    '{ROW_BYTE, '0, 32'h55, GOLD_CALC, '{8'h00, KIND_PAY}},
    '{ROW_REG, REG_CONTENT_LENGTH, 32'h0, GOLD_CALC, '{8'h00, KIND_PAY}},
    '{ROW_BYTE, '0, 32'hAA, GOLD_NONE, '{8'h00, KIND_PAY}},
    '{ROW_REG, REG_CHUNKED_MODE, 32'h1, GOLD_CALC, '{8'h00, KIND_PAY}}
  };

  logic clk = 1'b0;
  logic rst_n;

  hbd_in_if  in_ch ();
  hbd_out_if out_ch ();
  hbd_cfg_if cfg_ch ();

  http_body_dechunker_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // decoder state, mirrors the block
  phase_t             dec_phase     = PH_LEAD;
  logic [31:0]        chunk_left    = '0;
  logic [COUNT_WIDTH-1:0] payload_cnt = '0;
  int                 digits_seen   = 0;
  logic               trailer_blank = 1'b1;
  logic               mode_chunked  = 1'b0;
  logic [LEN_W-1:0]   body_len      = '0;

  word_t       decoded_q[$];
  int          word_errors = 0;
  int unsigned cyc = 0;
  int          quiet = 0;
  wire         calm = (cyc % 1200) >= 900;

  function automatic int hex_nibble(input logic [7:0] c);
    if (c >= "0" && c <= "9") return c - "0";
    if (c >= "a" && c <= "f") return c - "a" + 10;
    if (c >= "A" && c <= "F") return c - "A" + 10;
    return -1;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 10) return 8'("0" + n);
    return 8'(($urandom_range(1) ? "a" : "A") + n - 10);
  endfunction

  // any byte but cr, hex digits left out unless allowed
  function automatic logic [7:0] pick_byte(input bit hex_ok);
    logic [7:0] b;
    do b = 8'($urandom_range(255));
    while (b == CH_CR || (!hex_ok && hex_nibble(b) >= 0));
    return b;
  endfunction

  // one body byte through the decoder; returns 1 when it yields a word
  function automatic bit decode_step(input logic [7:0] c, output word_t w);
    int h;
    h = hex_nibble(c);
    w = '0;
    if (dec_phase == PH_DONE || dec_phase == PH_ERROR) return 1'b0;
    if (!mode_chunked) begin
      if (payload_cnt >= body_len) return 1'b0;
      payload_cnt = payload_cnt + 1'b1;
      w.data = c;
      if (payload_cnt == body_len) begin
        dec_phase = PH_DONE;
        w.kind = KIND_LAST;
      end
      return 1'b1;
    end
    case (dec_phase)
      PH_LEAD: begin
        if (c == CH_SPACE || c == CH_TAB) return 1'b0;
        if (h < 0) begin
          dec_phase = PH_ERROR;
          w.kind = KIND_BAD;
          return 1'b1;
        end
        chunk_left = h;
        digits_seen = 1;
        dec_phase = PH_DIGITS;
      end
      PH_DIGITS: begin
        if (h >= 0) begin
          if (digits_seen >= MAX_DIGITS) begin
            dec_phase = PH_ERROR;
            w.kind = KIND_BAD;
            return 1'b1;
          end
          chunk_left = {chunk_left[27:0], 4'(h)};
          digits_seen++;
        end else if (c == CH_CR) begin
          dec_phase = PH_LF;
        end else begin
          dec_phase = PH_EXT;
        end
      end
      PH_EXT: begin
        if (c == CH_CR) dec_phase = PH_LF;
      end
      PH_LF: begin
        if (chunk_left == 0) begin
          trailer_blank = 1'b1;
          dec_phase = PH_TRAIL;
        end else begin
          dec_phase = PH_DATA;
        end
      end
      PH_DATA: begin
        chunk_left--;
        payload_cnt = payload_cnt + 1'b1;
        if (chunk_left == 0) dec_phase = PH_POST1;
        w.data = c;
        return 1'b1;
      end
      PH_POST1: begin
        dec_phase = PH_POST2;
      end
      PH_POST2: begin
        digits_seen = 0;
        dec_phase = PH_LEAD;
      end
      PH_TRAIL: begin
        if (c == CH_CR) dec_phase = PH_TLF;
        else trailer_blank = 1'b0;
      end
      PH_TLF: begin
        if (trailer_blank) begin
          dec_phase = PH_DONE;
          w.kind = KIND_END;
          return 1'b1;
        end
        trailer_blank = 1'b1;
        dec_phase = PH_TRAIL;
      end
      default: begin
        dec_phase = PH_ERROR;
      end
    endcase
    return 1'b0;
  endfunction

  task automatic drive_byte(input logic [7:0] b);
    while (!calm && $urandom_range(99) < 21) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.in_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic feed(input logic [7:0] b);
    word_t w;
    if (decode_step(b, w)) decoded_q.insert(decoded_q.size(), w);
    drive_byte(b);
  endtask

  // stop sending and let every word in flight come out
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] v);
    settle();
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.wdata <= v;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    if (idx == REG_CHUNKED_MODE) mode_chunked = v[0];
    else body_len = v;
  endtask

  // a few bytes in length mode, never reaching the length, then back to chunked
  task automatic length_detour();
    int n;
    logic [31:0] len;
    n = $urandom_range(20, 1);
    case ($urandom_range(3))
      0: len = payload_cnt + n + $urandom_range(1000, 1);
      1: len = '1;
      2: len = 32'h8000_0000 | $urandom();
      default: len = $urandom_range(payload_cnt);
    endcase
    write_reg(REG_CHUNKED_MODE, 32'h0);
    write_reg(REG_CONTENT_LENGTH, len);
    repeat (n) feed(8'($urandom_range(255)));
    write_reg(REG_CHUNKED_MODE, 32'h1);
  endtask

  task automatic send_chunk(inout int fed);
    logic [7:0] line[$];
    logic [31:0] size;
    int r, need, ndig, split;
    r = $urandom_range(99);
    if (r < 70) size = $urandom_range(16, 1);
    else if (r < 95) size = $urandom_range(64, 17);
    else size = $urandom_range(400, 65);
    if ($urandom_range(3) == 0) begin
      repeat ($urandom_range(3, 1))
        line.insert(line.size(), $urandom_range(1) ? CH_SPACE : CH_TAB);
    end
    need = 1;
    while ((size >> (4 * need)) != 0) need++;
    ndig = $urandom_range(1) ? need : $urandom_range(MAX_DIGITS, need);
    for (int i = ndig - 1; i >= 0; i--) begin
      line.insert(line.size(), hex_char(4'(size >> (4 * i))));
    end
    if ($urandom_range(3) == 0) begin
      line.insert(line.size(), pick_byte(1'b0));
      repeat ($urandom_range(5)) line.insert(line.size(), pick_byte(1'b1));
    end
    line.insert(line.size(), CH_CR);
    line.insert(line.size(), $urandom_range(3) != 0 ? 8'h0A : 8'($urandom_range(255)));
    repeat (size) line.insert(line.size(), 8'($urandom_range(255)));
    if ($urandom_range(3) != 0) begin
      line.insert(line.size(), CH_CR);
      line.insert(line.size(), 8'h0A);
    end else begin
      repeat (2) line.insert(line.size(), 8'($urandom_range(255)));
    end
    // now and then switch modes in the middle of the chunk
    split = ($urandom_range(7) == 0) ? int'($urandom_range(line.size() - 1)) : -1;
    foreach (line[i]) begin
      if (i == split) length_detour();
      feed(line[i]);
    end
    fed += line.size();
  endtask

  always @(posedge clk) begin
    cyc <= cyc + 1;
    out_ch.ready <= calm || ($urandom_range(99) >= 21);
  end

  always @(posedge clk) begin : check_words
    word_t head;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (decoded_q.size() == 0) begin
        $error("word with none pending: data %0h kind %0d", out_ch.data, out_ch.kind);
        word_errors++;
      end else begin
        head = decoded_q.pop_front();
        if (out_ch.data !== head.data) begin
          $error("data: expected %0h, got %0h", head.data, out_ch.data);
          word_errors++;
        end
        if (out_ch.kind !== head.kind) begin
          $error("kind: expected %0d, got %0d", head.kind, out_ch.kind);
          word_errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("** http_body_dechunker_core: FAILED **");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin : main
    word_t w;
    bit has;
    int fed;
    int n;
    logic [7:0] b;
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.in_byte  = '0;
    out_ch.ready   = 1'b0;
    cfg_ch.valid   = 1'b0;
    cfg_ch.index   = '0;
    cfg_ch.wdata   = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < N_ROWS; r++) begin
      if (DIRECTED[r].op == ROW_REG) begin
        write_reg(DIRECTED[r].idx, DIRECTED[r].val);
      end else begin
        has = decode_step(DIRECTED[r].val[7:0], w);
        if (DIRECTED[r].gold == GOLD_WORD) begin
          decoded_q.insert(decoded_q.size(), DIRECTED[r].word);
        end else if (DIRECTED[r].gold == GOLD_CALC && has) begin
          decoded_q.insert(decoded_q.size(), w);
        end
        drive_byte(DIRECTED[r].val[7:0]);
      end
    end

    fed = 0;
    while (fed < RANDOM_BYTES) begin
      if ($urandom_range(9) == 0) length_detour();
      send_chunk(fed);
    end

    // one way to finish the body, since only reset leaves the end state
    case ($urandom_range(3))
      0: begin
        n = $urandom_range(30, 1);
        write_reg(REG_CHUNKED_MODE, 32'h0);
        write_reg(REG_CONTENT_LENGTH, payload_cnt + n);
        repeat (n + 3) feed(8'($urandom_range(255)));
      end
      1: begin
        if ($urandom_range(1)) feed(CH_SPACE);
        repeat ($urandom_range(MAX_DIGITS, 1)) feed("0");
        if ($urandom_range(1)) begin
          feed(pick_byte(1'b0));
          feed(pick_byte(1'b1));
        end
        feed(CH_CR);
        feed(8'h0A);
        repeat ($urandom_range(3)) begin
          repeat ($urandom_range(10, 1)) feed(pick_byte(1'b1));
          feed(CH_CR);
          feed(8'($urandom_range(255)));
        end
        feed(CH_CR);
        feed(8'h0A);
      end
      2: begin
        if ($urandom_range(1)) feed(CH_TAB);
        if ($urandom_range(1)) begin
          feed(CH_CR);
        end else begin
          do b = pick_byte(1'b0);
          while (b == CH_SPACE || b == CH_TAB);
          feed(b);
        end
      end
      default: begin
        repeat (MAX_DIGITS + 1) feed(hex_char(4'($urandom_range(15))));
      end
    endcase
    // stays finished in either mode
    repeat (4) feed(8'($urandom_range(255)));
    write_reg(REG_CHUNKED_MODE, {31'b0, !mode_chunked});
    repeat (4) feed(8'($urandom_range(255)));

    settle();
    if (word_errors == 0) begin
      $display("** http_body_dechunker_core: PASSED **");
    end else begin
      $display("** http_body_dechunker_core: FAILED **");
    end
    $finish;
  end

endmodule
